FILE: sv/aes_cmac_tag_assert.svh
// Assertion macros for the CMAC tag block.
// Used by aes_cmac_tag; no other dependencies.
`ifndef AES_CMAC_TAG_ASSERT_SVH
`define AES_CMAC_TAG_ASSERT_SVH
`ifndef SYNTHESIS
`define CMAC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CMAC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CMAC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CMAC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/acmac_pkg.sv
// Package for the CMAC tag block: state codes and AES helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acmac_pkg;
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LGEN = 5'b00010,
    ST_MSG  = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_PREP = 5'b10000
  } state_e;

  localparam logic [7:0] CMAC_RB  = 8'h87;
  localparam logic [7:0] CMAC_PAD = 8'h80;
  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a 128-bit block sits in bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(logic [127:0] v, int unsigned i);
    get_byte = v[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] next_round_key(logic [127:0] rk, logic [7:0] rc);
    logic [7:0] b [16];
    for (int i = 0; i < 16; i++) b[i] = get_byte(rk, i);
    b[0] = b[0] ^ SBOX[b[13]] ^ rc;
    b[1] = b[1] ^ SBOX[b[14]];
    b[2] = b[2] ^ SBOX[b[15]];
    b[3] = b[3] ^ SBOX[b[12]];
    for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i - 4];
    for (int i = 0; i < 16; i++) next_round_key[127 - 8 * i -: 8] = b[i];
  endfunction

  function automatic logic [127:0] aes_round(logic [127:0] s, logic [127:0] rk,
                                             logic final_round);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4 * c] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
    if (!final_round) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) aes_round[127 - 8 * i -: 8] = t[i] ^ get_byte(rk, i);
  endfunction

  function automatic logic [127:0] dbl(logic [127:0] v);
    dbl = {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CMAC_RB : 8'h00)};
  endfunction
endpackage
`default_nettype wire

FILE: sv/aes_cmac_tag.sv
// AES-128 CMAC tag: one AES round unit shared by L derivation and all blocks.
// Each accepted block is loaded in PREP and then run through the MSG rounds; L
// must first be derived in LGEN after reset or a key write. A new block is taken
// only in IDLE, once the last one is done and, after a final block, its tag is
// taken. Reset clears control, the key, the chaining value and the subkey-ready
// flag.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_cmac_tag_assert.svh"
module aes_cmac_tag (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // block_high, block_low, byte_count, pad
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata   // tag_high, tag_low
);
  import acmac_pkg::*;

  localparam logic [0:0] IdxKeyHigh = 1'b0;

  state_e       state_q, state_d;
  logic [127:0] key_q;
  logic [127:0] rk_q, rk_d;
  logic [127:0] st_q, st_d;
  logic [127:0] chain_q, chain_d;
  logic [127:0] l_q, l_d;
  logic [127:0] blk_q;
  logic [4:0]   cnt_q;
  logic         last_q;
  logic         ready_q, ready_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] tag_q, tag_d;
  logic [127:0] rk_next, st_next, pad_blk, k1, k2, fin;
  logic         acc;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {tag_q[63:0], tag_q[127:64]};

  assign rk_next = next_round_key(rk_q, RCON[rnd_q]);
  assign st_next = aes_round(st_q, rk_next, rnd_q == 4'(NumRounds - 1));

  always_comb begin
    k1 = dbl(l_q);
    k2 = dbl(k1);
    for (int i = 0; i < 16; i++)
      pad_blk[127 - 8 * i -: 8] = (i < int'(cnt_q)) ? get_byte(blk_q, i) :
                                 ((i == int'(cnt_q)) ? CMAC_PAD : 8'h00);
    fin = (cnt_q >= 5'd16) ? (blk_q ^ k1) : (pad_blk ^ k2);
  end

  always_comb begin
    state_d = state_q; rk_d = rk_q; st_d = st_q; chain_d = chain_q;
    l_d = l_q; ready_d = ready_q; rnd_d = rnd_q; tag_d = tag_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          rk_d = key_q; rnd_d = '0;
          if (!ready_q) begin
            st_d = key_q; state_d = ST_LGEN;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        rk_d = key_q; rnd_d = '0;
        st_d = (last_q ? (chain_q ^ fin) : (chain_q ^ blk_q)) ^ key_q;
        state_d = ST_MSG;
      end
      ST_LGEN: begin
        rk_d = rk_next; st_d = st_next; rnd_d = rnd_q + 4'd1;
        if (rnd_q == 4'(NumRounds - 1)) begin
          l_d = st_next; ready_d = 1'b1; state_d = ST_PREP;
        end
      end
      ST_MSG: begin
        rk_d = rk_next; st_d = st_next; rnd_d = rnd_q + 4'd1;
        if (rnd_q == 4'(NumRounds - 1)) begin
          if (last_q) begin
            tag_d = st_next; chain_d = '0; state_d = ST_OUT;
          end else begin
            chain_d = st_next; state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) ready_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= '0;
      ready_q <= 1'b0;
      rnd_q <= '0;
      key_q <= '0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      ready_q <= ready_d;
      rnd_q <= rnd_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == IdxKeyHigh) key_q[127:64] <= cfg_data_i;
        else key_q[63:0] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_d;
    st_q <= st_d;
    l_q <= l_d;
    tag_q <= tag_d;
    if (acc) begin
      blk_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      cnt_q <= (s_axis_tdata[132:128] > 5'd16) ? 5'd16 : s_axis_tdata[132:128];
      last_q <= s_axis_tlast;
    end
  end

  `CMAC_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `CMAC_ASSERT_NXT(a_tag_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `CMAC_ASSERT_NXT(a_chain_clear, clk_i, rst_ni, (state_q == ST_MSG) && last_q &&
                   (rnd_q == 4'(NumRounds - 1)), chain_q == '0)
  `CMAC_ASSERT_IMP(a_ready_in_msg, clk_i, rst_ni, state_q == ST_MSG, ready_q || cfg_we_i
                   || $past(cfg_we_i))
endmodule
`default_nettype wire
